// File: rtl/core/distinct_source_flood_detector_macros.svh
// Assertion macros for the flood detector.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef DISTINCT_SOURCE_FLOOD_DETECTOR_MACROS_SVH
`define DISTINCT_SOURCE_FLOOD_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/dsfd_pkg.sv
`timescale 1ns / 1ps

package dsfd_pkg;

	// Operation codes carried by an input item.
	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_REPORT = 2'd2;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_PERCENT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RATE    = 2'd1;
	localparam int CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [6:0]  PERCENT_RESET = 7'd90;
	localparam logic [15:0] RATE_RESET    = 16'd100;

	// Scale factors of the two cross-multiplied tests.
	localparam logic [15:0] PCT_SCALE = 16'd100;
	localparam logic [31:0] US_PER_S  = 32'd1000000;

	// Steps of the shared multiplier.
	localparam logic [2:0] MSTEP_PCT_RHS  = 3'd0;
	localparam logic [2:0] MSTEP_PCT_LHS  = 3'd1;
	localparam logic [2:0] MSTEP_RATE_LHS = 3'd2;
	localparam logic [2:0] MSTEP_RATE_LO  = 3'd3;
	localparam logic [2:0] MSTEP_RATE_HI  = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] source_ip;
		logic [47:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  distinct_count;
		logic [31:0] packet_total;
		logic [47:0] elapsed_us;
		logic        flood;
		logic        table_full;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY,
		ST_ELAPSE,
		ST_MULT,
		ST_FINISH
	} state_t;

endpackage

// File: rtl/core/distinct_source_flood_detector.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload      Handshake
// in        input      in_item_t    in_valid / in_stall
// out       output     out_item_t   out_valid / out_stall
// cfg       input      cfg_data     cfg_we, cfg_index
//
// A record item first searches the table at one stored entry per cycle through a single read
// port; clear and report items skip the search. Every item then makes five passes of the shared
// 32x16 multiplier, and no new item is taken until the last one has reached the output register.
// Reset clears all counters, stamps and flags at once; the table needs no pass. A stalled result
// holds in the output register; the next item is worked meanwhile and its result waits at the
// end, input stalled.

module distinct_source_flood_detector #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  dsfd_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output dsfd_pkg::out_item_t               out_item,
	input  logic                              cfg_we,
	input  logic [dsfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dsfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	dsfd_pkg::state_t state_q, state_d;

	// Configuration and accepted item.
	logic [6:0]          percent_q;
	logic [15:0]         rate_q;
	dsfd_pkg::in_item_t  item_q;

	// Detector state.
	logic [31:0]   table_mem [TABLE_DEPTH];
	logic [CW-1:0] count_q;
	logic [31:0]   packets_q;
	logic [47:0]   first_q;
	logic [47:0]   last_q;
	logic          overflow_q;

	// Search control.
	logic [CW-1:0] rd_idx_q;
	logic          cmp_valid_q;
	logic [31:0]   rd_data_q;
	logic          found_q;
	logic          issue;
	logic          hit;
	logic          search_done;

	// Arithmetic.
	logic [47:0] elapsed_q;
	logic        negative_q;
	logic [2:0]  mstep_q;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_p;
	logic [47:0] pct_lhs_q;
	logic [47:0] pct_rhs_q;
	logic [47:0] rate_lhs_q;
	logic [63:0] rate_rhs_q;

	// Result.
	dsfd_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                out_free;
	logic                flood;
	logic [CW+6:0]       count_ext;
	logic                room;

	assign hit         = cmp_valid_q && (rd_data_q == item_q.source_ip);
	assign issue       = (rd_idx_q < count_q) && !hit;
	assign search_done = hit || (!issue && !cmp_valid_q);
	assign out_free    = !out_valid_q || !out_stall;
	assign room        = count_q < CW'(TABLE_DEPTH);
	assign count_ext   = {7'd0, count_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsfd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_item.op == dsfd_pkg::OP_RECORD) ? dsfd_pkg::ST_SEARCH
						: dsfd_pkg::ST_APPLY;
				end
			end
			dsfd_pkg::ST_SEARCH: begin
				if (search_done) state_d = dsfd_pkg::ST_APPLY;
			end
			dsfd_pkg::ST_APPLY:  state_d = dsfd_pkg::ST_ELAPSE;
			dsfd_pkg::ST_ELAPSE: state_d = dsfd_pkg::ST_MULT;
			dsfd_pkg::ST_MULT: begin
				if (mstep_q == dsfd_pkg::MSTEP_RATE_HI) state_d = dsfd_pkg::ST_FINISH;
			end
			dsfd_pkg::ST_FINISH: begin
				if (out_free) state_d = dsfd_pkg::ST_IDLE;
			end
			default: state_d = dsfd_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_stall  = (state_q != dsfd_pkg::ST_IDLE);
		out_valid = out_valid_q;
		out_item  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			percent_q <= dsfd_pkg::PERCENT_RESET;
			rate_q    <= dsfd_pkg::RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsfd_pkg::REG_PERCENT: percent_q <= cfg_data[6:0];
				dsfd_pkg::REG_RATE:    rate_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Capture of the accepted item.
	always_ff @(posedge clk) begin
		if (state_q == dsfd_pkg::ST_IDLE && in_valid) item_q <= in_item;
	end

	// Source table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == dsfd_pkg::ST_APPLY && item_q.op == dsfd_pkg::OP_RECORD
				&& !found_q && room) begin
			table_mem[count_q[AW-1:0]] <= item_q.source_ip;
		end
		rd_data_q <= table_mem[rd_idx_q[AW-1:0]];
	end

	// Table search, one stored entry compared per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			cmp_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (state_q == dsfd_pkg::ST_SEARCH) begin
			cmp_valid_q <= issue;
			if (issue) rd_idx_q <= rd_idx_q + CW'(1);
			if (search_done) found_q <= hit;
		end else begin
			rd_idx_q    <= '0;
			cmp_valid_q <= 1'b0;
		end
	end

	// Counters, stamps and the sticky full flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			packets_q  <= '0;
			first_q    <= '0;
			last_q     <= '0;
			overflow_q <= 1'b0;
		end else if (state_q == dsfd_pkg::ST_APPLY) begin
			case (item_q.op)
				dsfd_pkg::OP_RECORD: begin
					if (packets_q == '0) first_q <= item_q.time_us;
					last_q <= item_q.time_us;
					if (packets_q != '1) packets_q <= packets_q + 32'd1;
					if (!found_q) begin
						if (room) count_q <= count_q + CW'(1);
						else overflow_q <= 1'b1;
					end
				end
				dsfd_pkg::OP_CLEAR: begin
					count_q    <= '0;
					packets_q  <= '0;
					first_q    <= '0;
					last_q     <= '0;
					overflow_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Elapsed time and its sign, taken once the stamps are settled.
	always_ff @(posedge clk) begin
		if (state_q == dsfd_pkg::ST_ELAPSE) begin
			if (packets_q == '0) begin
				elapsed_q  <= '0;
				negative_q <= 1'b0;
			end else if (last_q >= first_q) begin
				elapsed_q  <= last_q - first_q;
				negative_q <= 1'b0;
			end else begin
				elapsed_q  <= '0;
				negative_q <= 1'b1;
			end
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mstep_q)
			dsfd_pkg::MSTEP_PCT_RHS: begin
				mul_a = packets_q;
				mul_b = {9'd0, percent_q};
			end
			dsfd_pkg::MSTEP_PCT_LHS: begin
				mul_a = {{(32-CW){1'b0}}, count_q};
				mul_b = dsfd_pkg::PCT_SCALE;
			end
			dsfd_pkg::MSTEP_RATE_LHS: begin
				mul_a = dsfd_pkg::US_PER_S;
				mul_b = {{(16-CW){1'b0}}, count_q};
			end
			dsfd_pkg::MSTEP_RATE_LO: begin
				mul_a = elapsed_q[31:0];
				mul_b = rate_q;
			end
			dsfd_pkg::MSTEP_RATE_HI: begin
				mul_a = {16'd0, elapsed_q[47:32]};
				mul_b = rate_q;
			end
			default: ;
		endcase
	end

	assign mul_p = {16'd0, mul_a} * {32'd0, mul_b};

	// Multiplier sequencing; the wide product is built from two partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q <= dsfd_pkg::MSTEP_PCT_RHS;
		end else if (state_q == dsfd_pkg::ST_MULT) begin
			mstep_q <= (mstep_q == dsfd_pkg::MSTEP_RATE_HI) ? dsfd_pkg::MSTEP_PCT_RHS
				: mstep_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dsfd_pkg::ST_MULT) begin
			case (mstep_q)
				dsfd_pkg::MSTEP_PCT_RHS:  pct_rhs_q  <= mul_p;
				dsfd_pkg::MSTEP_PCT_LHS:  pct_lhs_q  <= mul_p;
				dsfd_pkg::MSTEP_RATE_LHS: rate_lhs_q <= mul_p;
				dsfd_pkg::MSTEP_RATE_LO:  rate_rhs_q <= {16'd0, mul_p};
				dsfd_pkg::MSTEP_RATE_HI:  rate_rhs_q <= rate_rhs_q + {mul_p[31:0], 32'd0};
				default: ;
			endcase
		end
	end

	// Flood decision from the registered products.
	always_comb begin
		flood = 1'b0;
		if (packets_q != '0 && pct_lhs_q >= pct_rhs_q) begin
			if (negative_q) flood = 1'b0;
			else if (elapsed_q == '0) flood = 1'b1;
			else flood = {16'd0, rate_lhs_q} > rate_rhs_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dsfd_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dsfd_pkg::ST_FINISH && out_free) begin
			out_q.distinct_count <= count_ext[6:0];
			out_q.packet_total   <= packets_q;
			out_q.elapsed_us     <= elapsed_q;
			out_q.flood          <= flood;
			out_q.table_full     <= overflow_q;
		end
	end

	// Checks on the table fill and the sequencer.
`include "distinct_source_flood_detector_macros.svh"

	`DSFD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH),
		"distinct count exceeds table depth")
	`DSFD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"block took a second item while busy")
	`DSFD_ASSERT_NOW(a_hit_needs_entry, state_q == dsfd_pkg::ST_SEARCH && hit,
		count_q != '0, "search matched in an empty table")
	`DSFD_ASSERT_NEXT(a_full_sticky,
		overflow_q && !(state_q == dsfd_pkg::ST_APPLY && item_q.op == dsfd_pkg::OP_CLEAR),
		overflow_q, "full flag dropped without a clear")

endmodule
